@@ rtl/core/bfts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfts_pkg
// Shared types and fixed field widths for the brute-force tour search core.
// ----------------------------------------------------------------------------
package bfts_pkg;

   localparam int CITY_FIELD_W  = 3;
   localparam int DIST_FIELD_W  = 8;
   localparam int TOUR_COST_W   = 11;
   localparam int NUM_CITIES_W  = 4;

   localparam logic [TOUR_COST_W-1:0]  COST_FIELD_MAX   = 11'd2047;
   localparam logic [NUM_CITIES_W-1:0] NUM_CITIES_RESET = 4'd8;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic start;
      logic walk_step;
      logic close_read;
      logic finish;
      logic emit;
   } bfts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_step;
      logic wrap;
      logic emit_empty;
   } bfts_sts_type;

endpackage
`default_nettype wire

@@ rtl/core/bfts_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/bfts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfts_ctrl
// Sequencer for loads, the tour walk, the cost check and the result emission.
// ----------------------------------------------------------------------------
module bfts_ctrl
   import bfts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_type,
   output      logic         req_stall,
   input  wire bfts_sts_type sts,
   output      bfts_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WALK   = 3'd1;
   localparam logic [2:0] ST_CLOSE  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_LOAD)) begin
               cmd.load = 1'b1;
            end
            if (accept && (req_type == REQ_START)) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.close_read = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = sts.wrap ? ST_EMIT : ST_WALK;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/bfts_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfts_dp
// Datapath: distance memory, Lehmer-code ordering counter, tour walk,
// cost accumulation, best-tour store and result output register.
// ----------------------------------------------------------------------------
module bfts_dp
   import bfts_pkg::*;
#(
   parameter int MAX_CITIES = 8,
   parameter int DIST_BITS  = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bfts_cmd_type             cmd,
   output      bfts_sts_type             sts,
   input  wire logic                     csr_wr_en,
   input  wire logic [NUM_CITIES_W-1:0]  csr_wr_data,
   input  wire logic [CITY_FIELD_W-1:0]  req_row_city,
   input  wire logic [CITY_FIELD_W-1:0]  req_col_city,
   input  wire logic [DIST_FIELD_W-1:0]  req_distance,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [CITY_FIELD_W-1:0]  rsp_tour_city,
   output      logic [TOUR_COST_W-1:0]   rsp_tour_cost,
   output      logic                     rsp_last_city
);

   localparam int CITY_W = $clog2(MAX_CITIES);
   localparam int CNT_W  = $clog2(MAX_CITIES + 1);
   localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COST_W = DIST_BITS + $clog2(MAX_CITIES);

   // Configuration and search registers
   logic [NUM_CITIES_W-1:0] num_cities_ff, num_cities_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CITY_W-1:0]       dig_ff [MAX_CITIES];
   logic [CITY_W-1:0]       dig_in [MAX_CITIES];
   logic [CITY_W-1:0]       walk_dig_ff [MAX_CITIES];
   logic [CITY_W-1:0]       walk_dig_in [MAX_CITIES];
   logic [MAX_CITIES-1:0]   mask_ff, mask_in;
   logic [CITY_W-1:0]       step_ff, step_in;
   logic [CITY_W-1:0]       prev_ff, prev_in;
   logic [CITY_W-1:0]       first_ff, first_in;
   logic [CITY_W-1:0]       trial_ff [MAX_CITIES];
   logic [CITY_W-1:0]       trial_in [MAX_CITIES];
   logic [CITY_W-1:0]       best_ff [MAX_CITIES];
   logic [CITY_W-1:0]       best_in [MAX_CITIES];
   logic [COST_W-1:0]       acc_ff, acc_in;
   logic [COST_W-1:0]       best_cost_ff, best_cost_in;
   logic                    first_tour_ff, first_tour_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    rd_valid_ff;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [CNT_W-1:0]        emit_cnt_ff, emit_cnt_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CITY_FIELD_W-1:0] rsp_city_ff, rsp_city_in;
   logic [TOUR_COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic [CNT_W-1:0]        eff_n;
   logic [MAX_CITIES-1:0]   start_mask;
   logic [CITY_W-1:0]       sel_city;
   logic                    sel_found;
   logic [CNT_W-1:0]        rank;
   logic [CITY_W-1:0]       next_dig [MAX_CITIES];
   logic                    carry;
   logic [CITY_W-1:0]       dig_max;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DIST_BITS-1:0]    rd_data;
   logic [DIST_BITS-1:0]    rd_dist;
   logic [COST_W-1:0]       total;
   logic                    take_best;
   logic                    emit_fire;
   logic [TOUR_COST_W-1:0]  cost_sat;

   // Effective city count and the starting set of unused cities
   always_comb begin
      if (num_cities_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (32'(num_cities_ff) > MAX_CITIES) begin
         eff_n = CNT_W'(MAX_CITIES);
      end else begin
         eff_n = CNT_W'(num_cities_ff);
      end
   end

   always_comb begin
      for (int b = 0; b < MAX_CITIES; b++) begin
         start_mask[b] = (b < 32'(n_in));
      end
   end

   // Pick the k-th unused city, k being the current Lehmer digit.
   always_comb begin
      sel_city  = '0;
      sel_found = 1'b0;
      rank      = '0;
      for (int b = 0; b < MAX_CITIES; b++) begin
         if (mask_ff[b] && !sel_found && (rank == CNT_W'(walk_dig_ff[0]))) begin
            sel_city  = CITY_W'(b);
            sel_found = 1'b1;
         end
         rank = rank + CNT_W'(mask_ff[b]);
      end
   end

   // Mixed-radix increment of the Lehmer code: digit p counts up to n-1-p.
   always_comb begin
      carry   = 1'b1;
      dig_max = '0;
      for (int p = MAX_CITIES - 1; p >= 0; p--) begin
         next_dig[p] = dig_ff[p];
         dig_max     = CITY_W'(32'(n_ff) - 1 - p);
         if ((p < 32'(n_ff)) && carry) begin
            if (dig_ff[p] == dig_max) begin
               next_dig[p] = '0;
            end else begin
               next_dig[p] = dig_ff[p] + CITY_W'(1);
               carry       = 1'b0;
            end
         end
      end
   end

   // Distance memory with per-entry valid bits so reset reads as zero
   assign wr_en   = cmd.load && (32'(req_row_city) < MAX_CITIES)
                    && (32'(req_col_city) < MAX_CITIES);
   assign wr_addr = ADDR_W'(32'(req_row_city) * MAX_CITIES + 32'(req_col_city));
   assign rd_addr = cmd.close_read
                    ? ADDR_W'(32'(first_ff) * MAX_CITIES + 32'(prev_ff))
                    : ADDR_W'(32'(prev_ff) * MAX_CITIES + 32'(sel_city));

   bfts_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DIST_BITS'(req_distance)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_dist   = rd_valid_ff ? rd_data : '0;
   assign total     = acc_ff + COST_W'(rd_dist);
   assign take_best = first_tour_ff || (total < best_cost_ff);
   assign emit_fire = cmd.emit && (emit_cnt_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign cost_sat  = (32'(best_cost_ff) > 32'(COST_FIELD_MAX))
                      ? COST_FIELD_MAX : TOUR_COST_W'(best_cost_ff);

   always_comb begin
      num_cities_in = csr_wr_en ? csr_wr_data : num_cities_ff;
      n_in          = cmd.start ? eff_n : n_ff;
      dig_in        = dig_ff;
      walk_dig_in   = walk_dig_ff;
      mask_in       = mask_ff;
      step_in       = step_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      trial_in      = trial_ff;
      best_in       = best_ff;
      acc_in        = rd_pend_ff ? (acc_ff + COST_W'(rd_dist)) : acc_ff;
      best_cost_in  = best_cost_ff;
      first_tour_in = first_tour_ff;
      rd_pend_in    = (cmd.walk_step && (step_ff != '0)) || cmd.close_read;
      valid_in      = valid_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_city_in   = rsp_city_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_last_in   = rsp_last_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (cmd.start) begin
         for (int p = 0; p < MAX_CITIES; p++) begin
            dig_in[p]      = '0;
            walk_dig_in[p] = '0;
         end
         mask_in       = start_mask;
         step_in       = '0;
         acc_in        = '0;
         first_tour_in = 1'b1;
      end

      if (cmd.walk_step) begin
         trial_in[step_ff] = sel_city;
         mask_in[sel_city] = 1'b0;
         prev_in           = sel_city;
         if (step_ff == '0) begin
            first_in = sel_city;
         end
         for (int p = 0; p < MAX_CITIES - 1; p++) begin
            walk_dig_in[p] = walk_dig_ff[p + 1];
         end
         walk_dig_in[MAX_CITIES - 1] = '0;
         step_in = step_ff + CITY_W'(1);
      end

      if (cmd.finish) begin
         if (take_best) begin
            best_cost_in = total;
            best_in      = trial_ff;
         end
         first_tour_in = 1'b0;
         acc_in        = '0;
         dig_in        = next_dig;
         walk_dig_in   = next_dig;
         mask_in       = start_mask;
         step_in       = '0;
         if (carry) begin
            emit_cnt_in = n_ff;
         end
      end

      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_city_in  = CITY_FIELD_W'(best_ff[0]);
         rsp_cost_in  = cost_sat;
         rsp_last_in  = (emit_cnt_ff == CNT_W'(1));
         for (int p = 0; p < MAX_CITIES - 1; p++) begin
            best_in[p] = best_ff[p + 1];
         end
         emit_cnt_in = emit_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cities_ff <= NUM_CITIES_RESET;
         valid_ff      <= '0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
         first_tour_ff <= 1'b1;
      end else begin
         num_cities_ff <= num_cities_in;
         valid_ff      <= valid_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_pend_ff    <= rd_pend_in;
         first_tour_ff <= first_tour_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      dig_ff       <= dig_in;
      walk_dig_ff  <= walk_dig_in;
      mask_ff      <= mask_in;
      step_ff      <= step_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      trial_ff     <= trial_in;
      best_ff      <= best_in;
      acc_ff       <= acc_in;
      best_cost_ff <= best_cost_in;
      rd_valid_ff  <= valid_ff[rd_addr];
      rsp_city_ff  <= rsp_city_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign sts.last_step  = (32'(step_ff) == 32'(n_ff) - 1);
   assign sts.wrap       = carry;
   assign sts.emit_empty = (emit_cnt_ff == '0);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tour_city = rsp_city_ff;
   assign rsp_tour_cost = rsp_cost_ff;
   assign rsp_last_city = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/core/brute_force_tour_search_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brute_force_tour_search_core
// Exhaustive travelling-salesman search over a loaded distance matrix.
//
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_type, req_row_city,
//                                          req_col_city, req_distance
// rsp      out        rsp_valid/rsp_stall  rsp_tour_city, rsp_tour_cost,
//                                          rsp_last_city
// csr      in         csr_wr_en            csr_wr_data (num_cities)
//
// A load transaction writes one distance entry. A start transaction walks all
// n! orderings, each in n walk steps, a read for the closing edge and a
// compare, then gives n result transactions. Reset is synchronous and active
// high; it clears the distance matrix through per-entry valid bits and sets
// num_cities to 8. req_stall is high from a start until its last result is in
// the output register; rsp_stall holds it.
// ----------------------------------------------------------------------------
module brute_force_tour_search_core
   import bfts_pkg::*;
#(
   parameter int MAX_CITIES = 8,
   parameter int DIST_BITS  = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic                    req_type,
   input  wire logic [CITY_FIELD_W-1:0] req_row_city,
   input  wire logic [CITY_FIELD_W-1:0] req_col_city,
   input  wire logic [DIST_FIELD_W-1:0] req_distance,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [CITY_FIELD_W-1:0] rsp_tour_city,
   output      logic [TOUR_COST_W-1:0]  rsp_tour_cost,
   output      logic                    rsp_last_city,
   input  wire logic                    csr_wr_en,
   input  wire logic [NUM_CITIES_W-1:0] csr_wr_data
);

   // The controller sequences each transaction; the datapath holds the
   // matrix, the ordering counter and the best tour found so far.
   bfts_cmd_type cmd;
   bfts_sts_type sts;

   bfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Orderings are counted as a Lehmer code so that they come out in
   // lexicographic order; ties therefore keep the earlier tour.
   bfts_dp #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_row_city  (req_row_city),
      .req_col_city  (req_col_city),
      .req_distance  (req_distance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tour_city (rsp_tour_city),
      .rsp_tour_cost (rsp_tour_cost),
      .rsp_last_city (rsp_last_city)
   );

endmodule
`default_nettype wire
